FILE: sv/fpm_pkg.sv
// shared types and constants for the fault persistence monitor
`timescale 1ns / 1ps

package fpm_pkg;

  // table geometry, fixed by the stream field widths
  localparam int NUM_FAULTS     = 6;
  localparam int FAULT_IDX_W    = 3;
  localparam int OP_W           = 3;
  localparam int SUM_W          = $clog2(NUM_FAULTS + 1);
  localparam int COUNT_BITS_DEF = 16;
  localparam int OUT_COUNT_W    = 16;
  localparam int CONSEC_W       = 8;
  localparam int THRESH_W       = 8;
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(3);

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 2 * NUM_FAULTS + 1 + FAULT_IDX_W + SUM_W + OUT_COUNT_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY = 3'd0,
    OP_SET   = 3'd1,
    OP_CLEAR = 3'd2,
    OP_COUNT = 3'd3,
    OP_TICK  = 3'd4,
    OP_RESET = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND
  } ctrl_state_e;

  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // apply request to the table and register the result
  } fpm_cmd_t;

endpackage

FILE: sv/fpm_ctrl.sv
// controller state machine: request handshake, execute step, result handshake
`timescale 1ns / 1ps

module fpm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output fpm_pkg::fpm_cmd_t cmd_o
);

  fpm_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpm_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = fpm_pkg::ST_EXEC;
      end
      fpm_pkg::ST_EXEC: begin
        state_d = fpm_pkg::ST_SEND;
      end
      fpm_pkg::ST_SEND: begin
        if (m_axis_tready) state_d = fpm_pkg::ST_IDLE;
      end
      default: state_d = fpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      fpm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      fpm_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
      end
      fpm_pkg::ST_SEND: begin
        m_axis_tvalid = 1'b1;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/fpm_datapath.sv
// fault table, threshold register, tick logic and result register
`timescale 1ns / 1ps

module fpm_datapath #(
  parameter int COUNT_BITS = fpm_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fpm_pkg::fpm_cmd_t                   cmd_i,
  input  logic [fpm_pkg::IN_TDATA_W-1:0]      req_data_i,
  input  logic                                cfg_wr_i,
  input  logic [fpm_pkg::THRESH_W-1:0]        cfg_data_i,
  output logic [fpm_pkg::OUT_TDATA_W-1:0]     res_data_o
);

  localparam int NF  = fpm_pkg::NUM_FAULTS;
  localparam int IW  = fpm_pkg::FAULT_IDX_W;
  localparam int CW  = fpm_pkg::CONSEC_W;
  localparam int SW  = fpm_pkg::SUM_W;
  localparam int OCW = fpm_pkg::OUT_COUNT_W;
  localparam int PAD = fpm_pkg::OUT_TDATA_W - fpm_pkg::OUT_FIELD_W;

  logic [fpm_pkg::THRESH_W-1:0] thresh_q;
  logic [fpm_pkg::OP_W-1:0]     op_q;
  logic [IW-1:0]                idx_q;

  logic [NF-1:0]         act_q, act_d;
  logic [NF-1:0]         pers_q, pers_d;
  logic [COUNT_BITS-1:0] occ_q [NF];
  logic [COUNT_BITS-1:0] occ_d [NF];
  logic [CW-1:0]         con_q [NF];
  logic [CW-1:0]         con_d [NF];
  logic                  pf_q, pf_d;
  logic [IW-1:0]         ps_q, ps_d;
  logic [SW-1:0]         pn_q, pn_d;
  logic [SW-1:0]         total;
  logic                  idx_ok;

  logic [COUNT_BITS-1:0]     addr_occ;
  logic [OCW+COUNT_BITS-1:0] addr_occ_ext;
  logic [OCW-1:0]            addr_count;
  logic                      addr_act;
  logic                      addr_pers;
  logic [fpm_pkg::OUT_TDATA_W-1:0] res_q;

  assign idx_ok = (idx_q < IW'(NF));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= fpm_pkg::THRESH_RST;
    end else if (cfg_wr_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_data_i[fpm_pkg::OP_W-1:0];
      idx_q <= req_data_i[fpm_pkg::OP_W+IW-1:fpm_pkg::OP_W];
    end
  end

  // next table contents for the latched request
  always_comb begin
    act_d  = act_q;
    pers_d = pers_q;
    occ_d  = occ_q;
    con_d  = con_q;
    pf_d   = pf_q;
    ps_d   = ps_q;
    pn_d   = pn_q;
    total  = '0;
    case (op_q)
      fpm_pkg::OP_SET: begin
        if (idx_ok) begin
          act_d[idx_q] = 1'b1;
          if (occ_q[idx_q] != '1) occ_d[idx_q] = occ_q[idx_q] + COUNT_BITS'(1);
        end
      end
      fpm_pkg::OP_CLEAR: begin
        if (idx_ok) act_d[idx_q] = 1'b0;
      end
      fpm_pkg::OP_COUNT: begin
        if (idx_ok && occ_q[idx_q] != '1) occ_d[idx_q] = occ_q[idx_q] + COUNT_BITS'(1);
      end
      fpm_pkg::OP_TICK: begin
        pf_d = 1'b0;
        ps_d = IW'(NF);
        for (int i = 0; i < NF; i++) begin
          if (act_q[i]) begin
            // lowest active source wins
            if (!pf_d) begin
              pf_d = 1'b1;
              ps_d = IW'(i);
            end
            if (con_q[i] != '1) con_d[i] = con_q[i] + CW'(1);
            if (con_d[i] >= thresh_q) begin
              pers_d[i] = 1'b1;
              total     = total + SW'(1);
            end
          end else begin
            con_d[i]  = '0;
            pers_d[i] = 1'b0;
          end
        end
        pn_d = total;
      end
      fpm_pkg::OP_RESET: begin
        act_d  = '0;
        pers_d = '0;
        pf_d   = 1'b0;
        ps_d   = IW'(NF);
        pn_d   = '0;
        for (int i = 0; i < NF; i++) begin
          occ_d[i] = '0;
          con_d[i] = '0;
        end
      end
      default: begin
        act_d = act_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      pers_q <= '0;
      pf_q   <= 1'b0;
      ps_q   <= IW'(NF);
      pn_q   <= '0;
      for (int i = 0; i < NF; i++) begin
        occ_q[i] <= '0;
        con_q[i] <= '0;
      end
    end else if (cmd_i.execute) begin
      act_q  <= act_d;
      pers_q <= pers_d;
      pf_q   <= pf_d;
      ps_q   <= ps_d;
      pn_q   <= pn_d;
      occ_q  <= occ_d;
      con_q  <= con_d;
    end
  end

  // view of the addressed source after the step, zero when out of range
  always_comb begin
    addr_occ  = '0;
    addr_act  = 1'b0;
    addr_pers = 1'b0;
    if (idx_ok) begin
      addr_occ  = occ_d[idx_q];
      addr_act  = act_d[idx_q];
      addr_pers = pers_d[idx_q];
    end
  end

  assign addr_occ_ext = {{OCW{1'b0}}, addr_occ};
  assign addr_count   = addr_occ_ext[OCW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_q <= {{PAD{1'b0}}, addr_pers, addr_act, addr_count, pn_d, ps_d, pf_d, pers_d, act_d};
    end
  end

  assign res_data_o = res_q;

endmodule

FILE: sv/fault_persistence_monitor_core.sv
// fault persistence monitor top level: stream ports, threshold write port
// flow: a request is accepted in idle, applied to the table in the execute step,
//   where its result is registered, and offered in the send state
// a new request is accepted only after the last result has been taken, following the
//   idle / execute / send sequence of the controller; the result holds until taken
// reset: asynchronous active low, clears the fault table and summary,
//   primary index reads as the number of sources, threshold returns to 3
`timescale 1ns / 1ps

module fault_persistence_monitor_core #(
  parameter int COUNT_BITS = fpm_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] operation, [5:3] fault_index, [7:6] zero
  input  logic [fpm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] active_mask, [11:6] persistent_mask, [12] primary_valid,
  // [15:13] primary_index, [18:16] persistent_total, [34:19] addressed_count,
  // [35] addressed_active, [36] addressed_persistent, [39:37] zero
  output logic [fpm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpm_pkg::THRESH_W-1:0]      cfg_data_i
);

  fpm_pkg::fpm_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  fpm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  fpm_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_data_i (s_axis_tdata),
    .cfg_wr_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .res_data_o (m_axis_tdata)
  );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the fault persistence monitor core
`timescale 1ns / 1ps

module tb_top;

  // operation codes outside the defined set, handled as a query
  localparam logic [fpm_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [fpm_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned RESULT_LATENCY = 4;

  // one result, highest field declared first, active_mask in the lowest bits
  typedef struct packed {
    logic [2:0]                      pad;
    logic                            addr_persistent;
    logic                            addr_active;
    logic [fpm_pkg::OUT_COUNT_W-1:0] addr_count;
    logic [fpm_pkg::SUM_W-1:0]       persistent_total;
    logic [fpm_pkg::FAULT_IDX_W-1:0] primary_index;
    logic                            primary_valid;
    logic [fpm_pkg::NUM_FAULTS-1:0]  persistent_mask;
    logic [fpm_pkg::NUM_FAULTS-1:0]  active_mask;
  } fault_report_t;

  // fault table tracker: mirrors the table and queues the reports it predicts
  class fault_table_tracker;
    logic [fpm_pkg::THRESH_W-1:0]    threshold;
    logic [fpm_pkg::NUM_FAULTS-1:0]  active_bits;
    logic [fpm_pkg::NUM_FAULTS-1:0]  persist_bits;
    logic [fpm_pkg::OUT_COUNT_W-1:0] occurrences [fpm_pkg::NUM_FAULTS];
    logic [fpm_pkg::CONSEC_W-1:0]    consecutive [fpm_pkg::NUM_FAULTS];
    logic                            primary_found;
    logic [fpm_pkg::FAULT_IDX_W-1:0] primary_src;
    logic [fpm_pkg::SUM_W-1:0]       persist_total;
    fault_report_t                   pending_reports [$];
    int unsigned                     mismatches;
    int unsigned                     requests_seen;
    int unsigned                     reports_checked;

    function new();
      threshold = fpm_pkg::THRESH_RST;
      mismatches = 0;
      requests_seen = 0;
      reports_checked = 0;
      clear_table();
    endfunction

    function void clear_table();
      active_bits = '0;
      persist_bits = '0;
      primary_found = 1'b0;
      primary_src = fpm_pkg::FAULT_IDX_W'(fpm_pkg::NUM_FAULTS);
      persist_total = '0;
      for (int i = 0; i < fpm_pkg::NUM_FAULTS; i++) begin
        occurrences[i] = '0;
        consecutive[i] = '0;
      end
    endfunction

    function void bump(int unsigned idx);
      if (occurrences[idx] != {fpm_pkg::OUT_COUNT_W{1'b1}}) occurrences[idx]++;
    endfunction

    function void run_tick();
      int unsigned total;
      total = 0;
      primary_found = 1'b0;
      primary_src = fpm_pkg::FAULT_IDX_W'(fpm_pkg::NUM_FAULTS);
      for (int i = 0; i < fpm_pkg::NUM_FAULTS; i++) begin
        if (active_bits[i]) begin
          if (!primary_found) begin
            primary_found = 1'b1;
            primary_src = fpm_pkg::FAULT_IDX_W'(i);
          end
          if (consecutive[i] != {fpm_pkg::CONSEC_W{1'b1}}) consecutive[i]++;
          // once persistent it stays so while active, even if the threshold rises
          if (consecutive[i] >= threshold) begin
            persist_bits[i] = 1'b1;
            total++;
          end
        end else begin
          consecutive[i] = '0;
          persist_bits[i] = 1'b0;
        end
      end
      persist_total = fpm_pkg::SUM_W'(total);
    endfunction

    function void note_request(logic [fpm_pkg::OP_W-1:0] op,
                               logic [fpm_pkg::FAULT_IDX_W-1:0] idx);
      logic in_range;
      fault_report_t rep;
      in_range = (idx < fpm_pkg::NUM_FAULTS);
      requests_seen++;
      case (op)
        fpm_pkg::OP_SET: begin
          if (in_range) begin
            active_bits[idx] = 1'b1;
            bump(idx);
          end
        end
        fpm_pkg::OP_CLEAR: begin
          if (in_range) active_bits[idx] = 1'b0;
        end
        fpm_pkg::OP_COUNT: begin
          if (in_range) bump(idx);
        end
        fpm_pkg::OP_TICK:  run_tick();
        fpm_pkg::OP_RESET: clear_table();
        default: ;
      endcase
      rep = '0;
      rep.active_mask = active_bits;
      rep.persistent_mask = persist_bits;
      rep.primary_valid = primary_found;
      rep.primary_index = primary_src;
      rep.persistent_total = persist_total;
      if (in_range) begin
        rep.addr_count = occurrences[idx];
        rep.addr_active = active_bits[idx];
        rep.addr_persistent = persist_bits[idx];
      end
      pending_reports.push_back(rep);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(logic [fpm_pkg::OUT_TDATA_W-1:0] data);
      fault_report_t got;
      fault_report_t want;
      got = fault_report_t'(data);
      if (pending_reports.size() == 0) begin
        $error("result with no request outstanding: %h", data);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      check_field("active_mask", want.active_mask, got.active_mask);
      check_field("persistent_mask", want.persistent_mask, got.persistent_mask);
      check_field("primary_valid", want.primary_valid, got.primary_valid);
      check_field("primary_index", want.primary_index, got.primary_index);
      check_field("persistent_total", want.persistent_total, got.persistent_total);
      check_field("addressed_count", want.addr_count, got.addr_count);
      check_field("addressed_active", want.addr_active, got.addr_active);
      check_field("addressed_persistent", want.addr_persistent, got.addr_persistent);
    endfunction

    function int unsigned outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [fpm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [fpm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fpm_pkg::THRESH_W-1:0]    cfg_data = '0;

  fault_table_tracker tracker = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned threshold_writes = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  fault_persistence_monitor_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  // result side: random stalls, plus long hold-offs counted here
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) tracker.check_report(m_axis_tdata);
  end

  task automatic send_request(input logic [fpm_pkg::OP_W-1:0] op,
                              input logic [fpm_pkg::FAULT_IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, idx, op};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(op, idx);
  endtask

  // sender pauses until every request has been answered
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [fpm_pkg::THRESH_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    tracker.threshold = value;
    threshold_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // mostly set/clear/tick traffic on valid sources so faults get a chance to persist
  task automatic random_requests(input int unsigned count);
    int unsigned r;
    logic [fpm_pkg::OP_W-1:0] op;
    logic [fpm_pkg::FAULT_IDX_W-1:0] idx;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 28) op = fpm_pkg::OP_SET;
      else if (r < 43) op = fpm_pkg::OP_CLEAR;
      else if (r < 53) op = fpm_pkg::OP_COUNT;
      else if (r < 83) op = fpm_pkg::OP_TICK;
      else if (r < 91) op = fpm_pkg::OP_QUERY;
      else if (r < 93) op = fpm_pkg::OP_RESET;
      else op = ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      if ($urandom_range(99) < 88) begin
        idx = fpm_pkg::FAULT_IDX_W'($urandom_range(fpm_pkg::NUM_FAULTS - 1));
      end else begin
        idx = fpm_pkg::FAULT_IDX_W'($urandom_range(7, fpm_pkg::NUM_FAULTS));
      end
      send_request(op, idx);
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    drain_results();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default threshold, every operation, out-of-range sources
    send_request(fpm_pkg::OP_QUERY, 3'd0);
    send_request(fpm_pkg::OP_SET, 3'd0);
    send_request(fpm_pkg::OP_SET, 3'd5);
    send_request(fpm_pkg::OP_SET, 3'd6);
    send_request(fpm_pkg::OP_SET, 3'd7);
    send_request(fpm_pkg::OP_COUNT, 3'd3);
    send_request(fpm_pkg::OP_COUNT, 3'd7);
    send_request(fpm_pkg::OP_CLEAR, 3'd0);
    send_request(fpm_pkg::OP_CLEAR, 3'd6);
    send_request(fpm_pkg::OP_TICK, 3'd0);
    send_request(fpm_pkg::OP_TICK, 3'd7);
    send_request(fpm_pkg::OP_TICK, 3'd5);
    send_request(fpm_pkg::OP_QUERY, 3'd5);
    send_request(OP_SPARE_LO, 3'd5);
    send_request(OP_SPARE_HI, 3'd1);
    send_request(fpm_pkg::OP_CLEAR, 3'd5);
    send_request(fpm_pkg::OP_TICK, 3'd5);
    send_request(fpm_pkg::OP_SET, 3'd2);
    send_request(fpm_pkg::OP_SET, 3'd4);
    send_request(fpm_pkg::OP_TICK, 3'd2);
    send_request(fpm_pkg::OP_RESET, 3'd2);
    send_request(fpm_pkg::OP_QUERY, 3'd2);
    send_request(fpm_pkg::OP_TICK, 3'd0);

    // zero threshold: persistent on the first tick
    write_threshold(8'd0);
    send_request(fpm_pkg::OP_SET, 3'd1);
    send_request(fpm_pkg::OP_SET, 3'd3);
    send_request(fpm_pkg::OP_TICK, 3'd1);
    send_request(fpm_pkg::OP_CLEAR, 3'd1);
    send_request(fpm_pkg::OP_TICK, 3'd3);

    // top threshold: long run of ticks, consecutive count pins at its limit
    write_threshold(8'd255);
    send_request(fpm_pkg::OP_RESET, 3'd0);
    send_request(fpm_pkg::OP_SET, 3'd4);
    for (int i = 0; i < 300; i++) send_request(fpm_pkg::OP_TICK, 3'd4);
    send_request(fpm_pkg::OP_CLEAR, 3'd4);
    send_request(fpm_pkg::OP_TICK, 3'd4);

    // random phases under different idling
    set_idling(0, 0);
    write_threshold(8'd1);
    random_requests(200);

    set_idling(53, 0);
    write_threshold(fpm_pkg::THRESH_W'($urandom_range(5, 2)));
    random_requests(200);

    set_idling(0, 53);
    write_threshold(8'd3);
    random_requests(60);
    // result side goes quiet long enough to back the block up
    hold_request = 80;
    random_requests(150);

    set_idling(22, 22);
    write_threshold(fpm_pkg::THRESH_W'($urandom_range(4, 1)));
    random_requests(100);
    drain_results();
    random_requests(110);

    drain_results();
    $display("%0d requests applied across %0d threshold writes", tracker.requests_seen,
             threshold_writes);
    $display("%0d results checked, %0d mismatches", tracker.reports_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("fault_persistence_monitor_core verification clean");
    end else begin
      $display("fault_persistence_monitor_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results outstanding", tracker.outstanding());
    $display("fault_persistence_monitor_core verification failed");
    $finish;
  end

endmodule

FILE: files.f
sv/fpm_pkg.sv
sv/fpm_ctrl.sv
sv/fpm_datapath.sv
sv/fault_persistence_monitor_core.sv
tb/tb_top.sv
